// ===== sv/ktldc_pkg.sv =====
// Shared types and constants for the keyed table with lazy delete and compaction.
// Holds table sizing, request/status codes, word structs and the controller state type.
// No dependencies.
package ktldc_pkg;

	// Table sizing
	localparam int CAPACITY   = 64;
	localparam int INFO_CHARS = 8;
	localparam int KEY_W      = 32;
	localparam int INFO_W     = 64;
	localparam int IDX_OUT_W  = 6;
	localparam int IDX_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W      = $clog2(CAPACITY + 1);

	// Match search is split into groups of cells
	localparam int GROUP      = 8;
	localparam int NGRP       = (CAPACITY + GROUP - 1) / GROUP;
	localparam int CAP_PAD    = NGRP * GROUP;

	// Info bytes kept on insert
	localparam logic [INFO_W-1:0] INFO_MASK = (INFO_CHARS >= 8) ? {INFO_W{1'b1}} :
		((INFO_W'(1) << (8 * INFO_CHARS)) - INFO_W'(1));

	// Request codes
	localparam logic [1:0] REQ_INSERT = 2'd0;
	localparam logic [1:0] REQ_REMOVE = 2'd1;
	localparam logic [1:0] REQ_LOOKUP = 2'd2;

	// Status codes
	localparam logic [1:0] STAT_OK       = 2'd0;
	localparam logic [1:0] STAT_DUP      = 2'd1;
	localparam logic [1:0] STAT_OVERFLOW = 2'd2;
	localparam logic [1:0] STAT_NOTFOUND = 2'd3;

	// Request word
	typedef struct packed {
		logic [1:0]              req_type;
		logic signed [KEY_W-1:0] key;
		logic [INFO_W-1:0]       info;
	} req_t;

	// Response word
	typedef struct packed {
		logic [1:0]           status;
		logic [IDX_OUT_W-1:0] index;
		logic [INFO_W-1:0]    found_info;
	} rsp_t;

	// Row-wide control for the cells
	typedef struct packed {
		logic compact;
		logic phase;
	} cell_ctl_t;

	// Result of one match group
	typedef struct packed {
		logic              hit;
		logic [GROUP-1:0]  first;
		logic [INFO_W-1:0] info;
	} grp_t;

	// Controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MATCH,
		ST_GROUP,
		ST_DECIDE,
		ST_COMPACT,
		ST_DONE
	} state_t;

endpackage

// ===== sv/ktldc_cell.sv =====
// One table cell: key, info and busy mark, with its own key compare and
// odd-even exchange toward its left neighbor. Depends on ktldc_pkg.
module ktldc_cell
	import ktldc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  cell_ctl_t         ctl,
	input  logic              odd,
	input  logic              wr,
	input  logic              clr,
	input  logic [KEY_W-1:0]  wr_key,
	input  logic [INFO_W-1:0] wr_info,
	input  logic [KEY_W-1:0]  cmp_key,
	input  logic [KEY_W-1:0]  right_key,
	input  logic [INFO_W-1:0] right_info,
	input  logic              right_busy,
	input  logic              left_busy,
	output logic [KEY_W-1:0]  key,
	output logic [INFO_W-1:0] info,
	output logic              busy,
	output logic              match
);

	logic [KEY_W-1:0]  key_q;
	logic [INFO_W-1:0] info_q;
	logic              busy_q;
	logic              match_q;
	logic              lower;
	logic              take;
	logic              give;

	// This cell is the left half of the exchanging pair when its parity equals the phase
	assign lower = (odd == ctl.phase);
	assign take  = ctl.compact && lower && !busy_q && right_busy;
	assign give  = ctl.compact && !lower && !left_busy && busy_q;

	// Busy mark
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (wr) begin
			busy_q <= 1'b1;
		end else if (clr || give) begin
			busy_q <= 1'b0;
		end else if (take) begin
			busy_q <= 1'b1;
		end
	end

	// Key and info payload
	always_ff @(posedge clk) begin
		if (wr) begin
			key_q  <= wr_key;
			info_q <= wr_info;
		end else if (take) begin
			key_q  <= right_key;
			info_q <= right_info;
		end
	end

	// Registered key compare
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= 1'b0;
		end else begin
			match_q <= busy_q && (key_q == cmp_key);
		end
	end

	assign key   = key_q;
	assign info  = info_q;
	assign busy  = busy_q;
	assign match = match_q;

endmodule

// ===== sv/ktldc_grp.sv =====
// First-match stage for one group of cells: picks the lowest matching cell
// and its info, registered. Depends on ktldc_pkg.
module ktldc_grp
	import ktldc_pkg::*;
(
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [GROUP-1:0]             match,
	input  logic [GROUP-1:0][INFO_W-1:0] info,
	output grp_t                         res
);

	grp_t res_c;
	grp_t res_q;
	logic taken;

	// Priority pick inside the group
	always_comb begin
		res_c = '0;
		taken = 1'b0;
		for (int l = 0; l < GROUP; l++) begin
			if (match[l] && !taken) begin
				taken          = 1'b1;
				res_c.first[l] = 1'b1;
				res_c.info     = info[l];
			end
		end
		res_c.hit = taken;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_q <= '0;
		end else begin
			res_q <= res_c;
		end
	end

	assign res = res_q;

endmodule

// ===== sv/keyed_table_lazy_delete_compact_unit.sv =====
// Top level of the keyed table: a row of cells, the grouped match stages and
// the request controller. Depends on ktldc_pkg, ktldc_cell and ktldc_grp.
//
// One request word is worked at a time. From its accept edge to its response
// being registered a word passes through key compare in every cell, first
// match per group of eight cells, pick across groups, then the action.
// The next word is taken the cycle after that; a response held by the
// receiver holds the action stage. An insert that meets a full table
// holding removed entries first compacts the cell row by odd-even neighbor
// exchange. The response register lets the next request be taken while a
// response waits. Busy marks clear at reset; there is no clearing pass.
module keyed_table_lazy_delete_compact_unit
	import ktldc_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	state_t state_q;
	state_t state_d;

	logic [1:0]        type_q;
	logic [KEY_W-1:0]  key_q;
	logic [INFO_W-1:0] info_q;

	logic [CNT_W-1:0]  used_q;
	logic [CNT_W-1:0]  busy_cnt_q;
	logic [CNT_W-1:0]  rnd_q;

	logic              hit_q;
	logic [IDX_W-1:0]  idx_q;
	logic [INFO_W-1:0] found_q;
	logic [CAPACITY-1:0] sel_q;

	logic              rsp_valid_q;
	rsp_t              rsp_q;

	cell_ctl_t         ctl;
	logic              fire;
	logic              accept;
	logic              need_compact;
	logic              do_ins;
	logic              do_rem;
	rsp_t              rsp_c;

	logic [CAPACITY-1:0]             cell_busy;
	logic [CAPACITY-1:0]             cell_match;
	logic [CAPACITY-1:0][KEY_W-1:0]  cell_key;
	logic [CAPACITY-1:0][INFO_W-1:0] cell_info;
	logic [CAPACITY-1:0]             cell_wr;

	logic [CAP_PAD-1:0]              match_pad;
	logic [CAP_PAD-1:0][INFO_W-1:0]  info_pad;
	grp_t                            grp [NGRP];

	logic              pick_hit;
	logic [IDX_W-1:0]  pick_idx;
	logic [INFO_W-1:0] pick_info;
	logic [CAP_PAD-1:0] pick_sel;

	assign accept = req_valid && !req_stall;
	assign fire   = (state_q == ST_DONE) && (!rsp_valid_q || !rsp_stall);

	// Cell row
	assign ctl.compact = (state_q == ST_COMPACT);
	assign ctl.phase   = rnd_q[0];

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [KEY_W-1:0]  r_key;
		logic [INFO_W-1:0] r_info;
		logic              r_busy;
		logic              l_busy;

		if (i == CAPACITY - 1) begin : g_last
			assign r_key  = '0;
			assign r_info = '0;
			assign r_busy = 1'b0;
		end else begin : g_mid
			assign r_key  = cell_key[i+1];
			assign r_info = cell_info[i+1];
			assign r_busy = cell_busy[i+1];
		end

		if (i == 0) begin : g_first
			assign l_busy = 1'b1;
		end else begin : g_rest
			assign l_busy = cell_busy[i-1];
		end

		assign cell_wr[i] = do_ins && (used_q == CNT_W'(i));

		ktldc_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.odd        (1'(i % 2)),
			.wr         (cell_wr[i]),
			.clr        (do_rem && sel_q[i]),
			.wr_key     (key_q),
			.wr_info    (info_q & INFO_MASK),
			.cmp_key    (key_q),
			.right_key  (r_key),
			.right_info (r_info),
			.right_busy (r_busy),
			.left_busy  (l_busy),
			.key        (cell_key[i]),
			.info       (cell_info[i]),
			.busy       (cell_busy[i]),
			.match      (cell_match[i])
		);
	end

	// Pad the row up to whole groups
	for (genvar i = 0; i < CAP_PAD; i++) begin : g_pad
		if (i < CAPACITY) begin : g_real
			assign match_pad[i] = cell_match[i];
			assign info_pad[i]  = cell_info[i];
		end else begin : g_fill
			assign match_pad[i] = 1'b0;
			assign info_pad[i]  = '0;
		end
	end

	// Group match stages
	for (genvar g = 0; g < NGRP; g++) begin : g_grp
		ktldc_grp u_grp (
			.clk    (clk),
			.arst_n (arst_n),
			.match  (match_pad[g*GROUP +: GROUP]),
			.info   (info_pad[g*GROUP +: GROUP]),
			.res    (grp[g])
		);
	end

	// Pick the first group with a hit
	always_comb begin
		pick_hit  = 1'b0;
		pick_idx  = '0;
		pick_info = '0;
		pick_sel  = '0;
		for (int g = 0; g < NGRP; g++) begin
			if (grp[g].hit && !pick_hit) begin
				pick_hit  = 1'b1;
				pick_info = grp[g].info;
				for (int l = 0; l < GROUP; l++) begin
					if (grp[g].first[l]) begin
						pick_idx              = IDX_W'(g * GROUP + l);
						pick_sel[g*GROUP + l] = 1'b1;
					end
				end
			end
		end
	end

	// Decision registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
			sel_q <= '0;
		end else if (state_q == ST_DECIDE) begin
			hit_q <= pick_hit;
			sel_q <= pick_sel[CAPACITY-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DECIDE) begin
			idx_q   <= pick_idx;
			found_q <= pick_info;
		end
	end

	// Compaction only pays off when the table is full but not all busy
	assign need_compact = (type_q == REQ_INSERT) && !pick_hit &&
		(used_q == CNT_W'(CAPACITY)) && (busy_cnt_q != CNT_W'(CAPACITY));

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) state_d = ST_MATCH;
			end
			ST_MATCH:  state_d = ST_GROUP;
			ST_GROUP:  state_d = ST_DECIDE;
			ST_DECIDE: state_d = need_compact ? ST_COMPACT : ST_DONE;
			ST_COMPACT: begin
				if (rnd_q == CNT_W'(CAPACITY - 1)) state_d = ST_DONE;
			end
			ST_DONE: begin
				if (fire) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs of the controller
	always_comb begin
		req_stall = 1'b1;
		do_ins    = 1'b0;
		do_rem    = 1'b0;
		rsp_c     = '0;
		case (state_q)
			ST_IDLE: req_stall = 1'b0;
			ST_DONE: begin
				case (type_q)
					REQ_INSERT: begin
						if (hit_q) begin
							rsp_c.status = STAT_DUP;
						end else if (used_q == CNT_W'(CAPACITY)) begin
							rsp_c.status = STAT_OVERFLOW;
						end else begin
							do_ins = fire;
						end
					end
					REQ_REMOVE: begin
						if (hit_q) begin
							do_rem = fire;
						end else begin
							rsp_c.status = STAT_NOTFOUND;
						end
					end
					REQ_LOOKUP: begin
						if (hit_q) begin
							rsp_c.index      = IDX_OUT_W'(idx_q);
							rsp_c.found_info = found_q;
						end else begin
							rsp_c.status = STAT_NOTFOUND;
						end
					end
					default: rsp_c.status = STAT_OK;
				endcase
			end
			default: req_stall = 1'b1;
		endcase
	end

	// Controller state, counts and request word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			used_q     <= '0;
			busy_cnt_q <= '0;
			rnd_q      <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_COMPACT) begin
				rnd_q <= rnd_q + CNT_W'(1);
				if (rnd_q == CNT_W'(CAPACITY - 1)) used_q <= busy_cnt_q;
			end else begin
				rnd_q <= '0;
			end
			if (do_ins) begin
				used_q     <= used_q + CNT_W'(1);
				busy_cnt_q <= busy_cnt_q + CNT_W'(1);
			end else if (do_rem) begin
				busy_cnt_q <= busy_cnt_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			type_q <= req.req_type;
			key_q  <= req.key;
			info_q <= req.info;
		end
	end

	// Response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (fire) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) rsp_q <= rsp_c;
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`ifndef SYNTH
	// Busy count tracks the busy marks in the row
	a_busy_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(cell_busy) == busy_cnt_q)
		else $error("busy count out of step with busy marks");

	// Busy entries never exceed the used region
	a_used: assert property (@(posedge clk) disable iff (!arst_n)
		busy_cnt_q <= used_q)
		else $error("busy count above used count");

	// Compaction runs only on a full table
	a_compact_full: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_COMPACT) |-> (used_q == CNT_W'(CAPACITY)))
		else $error("compaction on a table that is not full");

	// The selected entry is one cell on a hit, none otherwise
	a_sel: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE) |-> (hit_q ? $onehot(sel_q) : (sel_q == '0)))
		else $error("bad entry select");

	// A new response appears only as a request finishes
	a_rsp_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(state_q == ST_DONE))
		else $error("response without a finished request");
`endif

endmodule
